/* hdl/srip_pkg.sv */
// Shared constants for the swap-remove ID pool: field widths, command codes
// and status codes. No dependencies.
`timescale 1ns / 1ps

package srip_pkg;

   localparam int unsigned POOL_SIZE_DEFAULT = 256;

   localparam int unsigned FIELD_W     = 8;
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned CAP_W       = 9;
   localparam int unsigned COUNT_OUT_W = 9;

   localparam int unsigned REQ_DATA_W = 2 * FIELD_W;
   localparam int unsigned REQ_USER_W = CMD_W;
   localparam int unsigned RSP_USED_W = FIELD_W + STATUS_W + COUNT_OUT_W;
   localparam int unsigned RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REM_SLOT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REM_ID   = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd4;

endpackage

/* hdl/swap_remove_id_pool.sv */
// Swap-remove ID pool: top level with the command sequencer, the count and
// limit registers and the result register. Depends on srip_pkg and srip_ram.
`timescale 1ns / 1ps
//
// The block hands out and takes back IDs. Commands arrive on the req_ stream
// (command in tuser, slot and target ID in tdata) and each one produces exactly
// one transfer on the rsp_ stream carrying the given ID, a status code and the
// active count after the command. The capacity limit is written through csr_.
// One command is worked at a time; req_tready is high only while the
// sequencer is idle. All table accesses go through the single read port and
// single write port of the table memory. Rejected commands and unused codes
// go straight to the result. Allocate reads the next free ID first;
// remove-at-slot reads the slot and last entries, then writes them swapped;
// remove-by-ID compares each active slot in turn, then swaps a hit with the
// last entry or reports a miss. A new command is taken the cycle after its
// predecessor's result is registered. If the receiver stalls, the result waits
// in the output register and at most one further command is worked up to its
// result before the sequencer waits. After reset the table is swept to the
// identity order with req_tready low; csr_ writes are taken throughout.

module swap_remove_id_pool #(
   parameter int unsigned POOL_SIZE = srip_pkg::POOL_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] slot_index, [15:8] target_id
   input  logic [srip_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command
   input  logic [srip_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] given_id, [10:8] status, [19:11] active_count, rest zero
   output logic [srip_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [srip_pkg::CAP_W-1:0]       csr_wdata
);
   import srip_pkg::*;

   localparam int unsigned IDW = $clog2(POOL_SIZE);
   localparam int unsigned CW  = $clog2(POOL_SIZE + 1);
   localparam int unsigned LW  = (CW > CAP_W) ? CW : CAP_W;
   localparam int unsigned SW  = (CW > FIELD_W) ? CW : FIELD_W;
   localparam int unsigned TW  = (IDW > FIELD_W) ? IDW : FIELD_W;
   localparam int unsigned OW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
   localparam int unsigned PAD_W = RSP_DATA_W - RSP_USED_W;

   localparam logic [3:0] S_INIT       = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_ALLOC_DATA = 4'd2;
   localparam logic [3:0] S_SCAN_RD    = 4'd3;
   localparam logic [3:0] S_SCAN_CMP   = 4'd4;
   localparam logic [3:0] S_DROP_RD_S  = 4'd5;
   localparam logic [3:0] S_DROP_RD_L  = 4'd6;
   localparam logic [3:0] S_DROP_WR_S  = 4'd7;
   localparam logic [3:0] S_DROP_WR_L  = 4'd8;
   localparam logic [3:0] S_DONE       = 4'd9;

   logic [3:0]            state_ff, state_in;
   logic [IDW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [IDW-1:0]        slot_ff, slot_in;
   logic [FIELD_W-1:0]    target_ff, target_in;
   logic [IDW-1:0]        held_ff, held_in;
   logic [FIELD_W-1:0]    given_ff, given_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic                  wr_en;
   logic [IDW-1:0]        wr_addr;
   logic [IDW-1:0]        wr_data;
   logic [IDW-1:0]        rd_addr;
   logic [IDW-1:0]        rd_data;

   logic [CMD_W-1:0]      req_cmd;
   logic [FIELD_W-1:0]    req_slot;
   logic [FIELD_W-1:0]    req_target;
   logic [LW-1:0]         limit;
   logic [CW-1:0]         count_dec;
   logic [IDW-1:0]        last;
   logic [OW-1:0]         count_out;

   srip_ram #(
      .DEPTH (POOL_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_cmd    = req_tuser[CMD_W-1:0];
   assign req_slot   = req_tdata[FIELD_W-1:0];
   assign req_target = req_tdata[2*FIELD_W-1:FIELD_W];

   assign limit     = (LW'(cap_ff) > LW'(POOL_SIZE)) ? LW'(POOL_SIZE) : LW'(cap_ff);
   assign count_dec = count_ff - CW'(1);
   assign last      = count_dec[IDW-1:0];
   assign count_out = OW'(count_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      target_in    = target_ff;
      held_in      = held_ff;
      given_in     = given_ff;
      status_in    = status_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = ptr_ff;
      rd_addr      = '0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + IDW'(1);
            if (ptr_ff == IDW'(POOL_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = count_ff[IDW-1:0];
            if (req_tvalid) begin
               cmd_in    = req_cmd;
               slot_in   = IDW'(req_slot);
               target_in = req_target;
               given_in  = '0;
               status_in = STAT_OK;
               state_in  = S_DONE;
               case (req_cmd)
                  CMD_ALLOC: begin
                     if (LW'(count_ff) >= limit) begin
                        status_in = STAT_FULL;
                     end else begin
                        state_in = S_ALLOC_DATA;
                     end
                  end
                  CMD_REM_SLOT: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else if (SW'(req_slot) >= SW'(count_ff)) begin
                        status_in = STAT_RANGE;
                     end else begin
                        state_in = S_DROP_RD_S;
                     end
                  end
                  CMD_REM_ID: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ALLOC_DATA: begin
            given_in = FIELD_W'(TW'(rd_data));
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_SCAN_RD: begin
            rd_addr  = ptr_ff;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (TW'(rd_data) == TW'(target_ff)) begin
               slot_in  = ptr_ff;
               held_in  = rd_data;
               state_in = S_DROP_RD_L;
            end else if (CW'(ptr_ff) == count_dec) begin
               status_in = STAT_MISSING;
               state_in  = S_DONE;
            end else begin
               ptr_in   = ptr_ff + IDW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_DROP_RD_S: begin
            rd_addr  = slot_ff;
            state_in = S_DROP_RD_L;
         end
         S_DROP_RD_L: begin
            rd_addr = last;
            if (cmd_ff == CMD_REM_SLOT) begin
               held_in = rd_data;
            end
            state_in = S_DROP_WR_S;
         end
         S_DROP_WR_S: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            state_in = S_DROP_WR_L;
         end
         S_DROP_WR_L: begin
            wr_en     = 1'b1;
            wr_addr   = last;
            wr_data   = held_ff;
            count_in  = count_dec;
            status_in = STAT_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = {{PAD_W{1'b0}}, count_out[COUNT_OUT_W-1:0], status_ff, given_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ptr_ff       <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      target_ff   <= target_in;
      held_ff     <= held_in;
      given_ff    <= given_in;
      status_ff   <= status_in;
      out_data_ff <= out_data_in;
   end

   // The active count never passes the pool size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(POOL_SIZE))
      else $error("active count above pool size");

   // The active count moves by at most one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1) || count_ff == $past(count_ff) - CW'(1)))
      else $error("active count jumped");

   // During the table sweep nothing is taken and nothing is offered.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> (!req_tready && !rsp_tvalid))
      else $error("handshake active during table sweep");

   // A delivered status is one of the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[FIELD_W+STATUS_W-1:FIELD_W] <= STAT_MISSING))
      else $error("undefined status code");

endmodule

/* hdl/srip_ram.sv */
// Permutation table storage: one write port and one read port with
// registered read data. Depends on srip_pkg for the default depth.
`timescale 1ns / 1ps

module srip_ram #(
   parameter int unsigned DEPTH = srip_pkg::POOL_SIZE_DEFAULT,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [AW-1:0] rd_data
);
   import srip_pkg::*;

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* bench/tb.sv */
// Testbench for swap_remove_id_pool: drives commands on req_, checks every rsp_ transfer
// against a local model of the ID table, count and capacity limit. Depends on srip_pkg.
`timescale 1ns / 1ps

module tb;
   import srip_pkg::*;

   localparam int unsigned POOL = POOL_SIZE_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [FIELD_W-1:0] slot;
      logic [FIELD_W-1:0] target;
   } pool_cmd_type;

   typedef struct packed {
      logic [FIELD_W-1:0]     given;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_OUT_W-1:0] count;
   } pool_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CAP_W-1:0]      csr_wdata = '0;

   logic [FIELD_W-1:0] pool_ids [POOL];
   logic [CAP_W-1:0]   pool_count;
   logic [CAP_W-1:0]   cap_limit;

   pool_cmd_type    pending_cmds [$];
   pool_result_type awaited_results [$];
   bit           offer_busy = 1'b0;
   bit           hold_armed = 1'b0;
   int           hold_left = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           fail_count = 0;
   int           stall_cycles = 0;

   swap_remove_id_pool u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void swap_out(int unsigned slot);
      logic [FIELD_W-1:0] held;
      int unsigned last;
      last = int'(pool_count) - 1;
      held = pool_ids[slot];
      pool_ids[slot] = pool_ids[last];
      pool_ids[last] = held;
      pool_count = CAP_W'(last);
   endfunction

   function automatic pool_result_type apply_command(logic [CMD_W-1:0] cmd,
                                                     logic [FIELD_W-1:0] slot,
                                                     logic [FIELD_W-1:0] target);
      pool_result_type r;
      int unsigned lim;
      int hit;
      r = '0;
      r.status = STAT_OK;
      lim = (int'(cap_limit) > POOL) ? POOL : int'(cap_limit);
      case (cmd)
         CMD_ALLOC: begin
            if (int'(pool_count) >= lim) begin
               r.status = STAT_FULL;
            end else begin
               r.given = pool_ids[pool_count];
               pool_count = pool_count + CAP_W'(1);
            end
         end
         CMD_REM_SLOT: begin
            if (pool_count == '0) begin
               r.status = STAT_EMPTY;
            end else if (CAP_W'(slot) >= pool_count) begin
               r.status = STAT_RANGE;
            end else begin
               swap_out(int'(slot));
            end
         end
         CMD_REM_ID: begin
            if (pool_count == '0) begin
               r.status = STAT_EMPTY;
            end else begin
               hit = -1;
               for (int i = 0; i < int'(pool_count); i++) begin
                  if (pool_ids[i] == target) begin
                     hit = i;
                     break;
                  end
               end
               if (hit < 0) begin
                  r.status = STAT_MISSING;
               end else begin
                  swap_out(hit);
               end
            end
         end
         default: begin
         end
      endcase
      r.count = pool_count;
      return r;
   endfunction

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      fail_count++;
      $display("%0t: mismatch on %0s: got %0d, want %0d", $realtime, field, got, want);
   endtask

   // Driver: presents one command at a time and predicts its result at the transfer.
   always @(posedge clock) begin
      pool_cmd_type item;
      pool_result_type r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r = apply_command(req_tuser, req_tdata[FIELD_W-1:0], req_tdata[2*FIELD_W-1:FIELD_W]);
            awaited_results.push_back(r);
            offer_busy = 1'b0;
         end
         if (!offer_busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item.cmd;
               req_tdata <= {item.target, item.slot};
               offer_busy = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and drives the receiver's stalls.
   always @(posedge clock) begin
      pool_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tdata[FIELD_W-1:0] !== want.given) begin
                  report_mismatch("given_id", rsp_tdata[FIELD_W-1:0], want.given);
               end
               if (rsp_tdata[FIELD_W+STATUS_W-1:FIELD_W] !== want.status) begin
                  report_mismatch("status", rsp_tdata[FIELD_W+STATUS_W-1:FIELD_W],
                                  want.status);
               end
               if (rsp_tdata[RSP_USED_W-1:FIELD_W+STATUS_W] !== want.count) begin
                  report_mismatch("active_count", rsp_tdata[RSP_USED_W-1:FIELD_W+STATUS_W],
                                  want.count);
               end
               if (rsp_tdata[RSP_DATA_W-1:RSP_USED_W] !== '0) begin
                  report_mismatch("padding", rsp_tdata[RSP_DATA_W-1:RSP_USED_W], 0);
               end
            end
         end
         if (hold_armed && awaited_results.size() != 0) begin
            hold_armed = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] slot,
                           logic [FIELD_W-1:0] target);
      pool_cmd_type item;
      while (pending_cmds.size() >= 2) @(posedge clock);
      item.cmd = cmd;
      item.slot = slot;
      item.target = target;
      pending_cmds.push_back(item);
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || offer_busy || awaited_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_limit(logic [CAP_W-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      cap_limit = value;
      csr_we <= 1'b0;
   endtask

   task automatic start_phase(int send_pct, int recv_pct, logic [CAP_W-1:0] value);
      write_limit(value);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic random_run(int n);
      int k;
      int roll;
      int cnt;
      int alloc_pct;
      logic [CMD_W-1:0] cmd;
      logic [FIELD_W-1:0] slot;
      logic [FIELD_W-1:0] target;
      alloc_pct = 50;
      for (k = 0; k < n; k++) begin
         if (k % 32 == 0) begin
            alloc_pct = $urandom_range(95, 10);
         end
         cnt = int'(pool_count);
         roll = $urandom_range(99);
         if (roll < alloc_pct) begin
            cmd = CMD_ALLOC;
         end else if (roll >= 97) begin
            cmd = CMD_UNUSED;
         end else if (roll % 2 == 0) begin
            cmd = CMD_REM_SLOT;
         end else begin
            cmd = CMD_REM_ID;
         end
         if (cnt > 0 && $urandom_range(99) < 85) begin
            slot = FIELD_W'($urandom_range(cnt - 1));
         end else begin
            slot = FIELD_W'($urandom_range(255));
         end
         if (cnt > 0 && $urandom_range(99) < 80) begin
            target = pool_ids[$urandom_range(cnt - 1)];
         end else begin
            target = FIELD_W'($urandom_range(255));
         end
         push_cmd(cmd, slot, target);
      end
   endtask

   initial begin
      for (int i = 0; i < POOL; i++) begin
         pool_ids[i] = FIELD_W'(i);
      end
      pool_count = '0;
      cap_limit = CAP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      start_phase(37, 61, CAP_RESET);
      push_cmd(CMD_REM_SLOT, 8'h00, 8'h00);
      push_cmd(CMD_REM_ID, 8'hFF, 8'hFF);
      push_cmd(CMD_UNUSED, 8'hFF, 8'hFF);
      write_limit(9'd0);
      push_cmd(CMD_ALLOC, 8'h00, 8'h00);
      write_limit(9'd1);
      push_cmd(CMD_ALLOC, 8'hFF, 8'hFF);
      push_cmd(CMD_ALLOC, 8'h00, 8'h00);
      write_limit(9'd511);
      push_cmd(CMD_ALLOC, 8'h00, 8'h00);
      push_cmd(CMD_ALLOC, 8'h00, 8'h00);
      push_cmd(CMD_ALLOC, 8'h00, 8'h00);
      push_cmd(CMD_REM_SLOT, 8'hFF, 8'h00);
      push_cmd(CMD_REM_SLOT, 8'h04, 8'h00);
      push_cmd(CMD_REM_SLOT, 8'h01, 8'h00);
      push_cmd(CMD_REM_ID, 8'h00, 8'hFF);
      push_cmd(CMD_REM_ID, 8'h00, 8'h01);
      push_cmd(CMD_REM_ID, 8'h00, 8'h00);
      push_cmd(CMD_ALLOC, 8'h00, 8'h00);
      push_cmd(CMD_REM_SLOT, 8'h00, 8'h00);
      write_limit(9'd1);
      push_cmd(CMD_ALLOC, 8'h00, 8'h00);
      push_cmd(CMD_REM_ID, 8'h00, 8'h03);
      push_cmd(CMD_REM_SLOT, 8'h00, 8'hFF);

      start_phase(37, 61, 9'd256);
      hold_armed = 1'b1;
      random_run(250);

      start_phase(61, 37, CAP_W'($urandom_range(255, 2)));
      random_run(200);

      start_phase(0, 0, 9'd511);
      for (int i = 0; i < POOL + 4; i++) begin
         push_cmd(CMD_ALLOC, FIELD_W'($urandom_range(255)), FIELD_W'($urandom_range(255)));
      end
      random_run(200);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/srip_pkg.sv
hdl/srip_ram.sv
hdl/swap_remove_id_pool.sv
bench/tb.sv
